/* hw/rtl/ske_pkg.sv */
// Shared widths, register indexes and defaults of the scalar Kalman estimator.
`timescale 1ns / 1ps
`default_nettype none

package ske_pkg;

   // Field widths of the transactions
   localparam int SAMPLE_W = 16;
   localparam int EST_W    = 32;
   localparam int VAR_W    = 32;

   // Innovation and multiplicand width (one guard bit over the estimate)
   localparam int DIFF_W = EST_W + 1;

   // Default count of fraction bits of every fixed-point value
   localparam int FRAC_BITS_DEF = 16;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [0:0] {
      CSR_MEAS_VAR = 1'b0,
      CSR_PROC_VAR = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

/* hw/rtl/ske_channels.sv */
// Valid/ready channel interfaces for samples in and estimates out.
`timescale 1ns / 1ps
`default_nettype none

interface ske_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ske_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ske_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [ske_pkg::EST_W-1:0] estimate;
   logic                             bypassed;

   modport source (output valid, output estimate, output bypassed, input ready);
   modport sink   (input valid, input estimate, input bypassed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ske_div.sv */
// Restoring divider: gain = floor(pp * 2^FRAC_BITS / den), one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ske_div #(
   parameter int FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ske_pkg::VAR_W-1:0]    numer,
   input  wire logic [ske_pkg::VAR_W:0]      denom,
   output logic      [FRAC_BITS-1:0]         quotient,
   output logic                              done
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam int REM_W = ske_pkg::VAR_W + 1;

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_W:0]       shifted;
   logic [REM_W+1:0]     trial;

   // Shift the partial remainder and try the subtraction
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
   end

   // Advance one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, numer};
         den_in  = denom;
         quo_in  = '0;
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[REM_W+1]) begin
            rem_in = shifted[REM_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
         end else begin
            rem_in = trial[REM_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/ske_mul.sv */
// Bit-serial multiplier: floor(m * x / 2^FRAC_BITS), one multiplier bit a cycle, LSB first.
`timescale 1ns / 1ps
`default_nettype none

module ske_mul #(
   parameter int FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [ske_pkg::DIFF_W-1:0]     multiplicand,
   input  wire logic        [FRAC_BITS-1:0]           multiplier,
   output logic signed      [ske_pkg::DIFF_W:0]       product,
   output logic                                       done
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam int ACC_W = ske_pkg::DIFF_W + 1;

   logic signed [ske_pkg::DIFF_W-1:0] x_ff, x_in;
   logic        [FRAC_BITS-1:0]       m_ff, m_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic        [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic signed [ACC_W:0]             sum;

   // Add the multiplicand for a set bit; the halving keeps the floor exact
   always_comb begin
      sum = {acc_ff[ACC_W-1], acc_ff} + (m_ff[0] ? (ACC_W+1)'(x_ff) : '0);
   end

   always_comb begin
      x_in    = x_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = multiplicand;
         m_in    = multiplier;
         acc_in  = '0;
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[ACC_W:1];
         m_in   = {1'b0, m_ff[FRAC_BITS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/scalar_kalman_estimator.sv */
// Top level of the scalar Kalman estimator: sequencer, state, register port, output stage.
`timescale 1ns / 1ps
`default_nettype none

// One sample in, one smoothed Q.FRAC_BITS estimate out. A filtered sample passes through
// the forming of the predicted variance, the restoring divider for the gain, the two bit-serial
// multipliers that run side by side for the estimate and the new variance, and the hand-off
// of the transaction to the output register; no new sample is taken until the block is idle
// again. With a measurement variance of zero the scaled sample is returned, flagged as
// bypassed, and the filter state is kept. The output register lets the next sample be
// taken while a result waits. Write the registers only while the block is idle.
module scalar_kalman_estimator #(
   parameter int FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ske_req_if.sink                                 req_ch,
   ske_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ske_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ske_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ske_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   localparam int EST_W  = ske_pkg::EST_W;
   localparam int VAR_W  = ske_pkg::VAR_W;
   localparam int DIFF_W = ske_pkg::DIFF_W;
   localparam int EXT_W  = ske_pkg::SAMPLE_W + FRAC_BITS + EST_W;

   localparam logic signed [EXT_W-1:0] EST_MAX = EXT_W'({1'b0, {(EST_W-1){1'b1}}});
   localparam logic signed [EXT_W-1:0] EST_MIN = -EST_MAX - EXT_W'(1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_PREDICT = 5'b00010,
      ST_DIVIDE  = 5'b00100,
      ST_MULT    = 5'b01000,
      ST_WRITE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [VAR_W-1:0]        meas_var_ff, meas_var_in;
   logic [VAR_W-1:0]        proc_var_ff, proc_var_in;
   logic signed [EST_W-1:0] prior_ff, prior_in;
   logic [VAR_W-1:0]        var_ff, var_in;
   logic signed [EST_W-1:0] scaled_ff, scaled_in;
   logic                    byp_ff, byp_in;
   logic [VAR_W-1:0]        pp_ff, pp_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [EST_W-1:0] out_est_ff, out_est_in;
   logic                    out_byp_ff, out_byp_in;

   logic                    req_take;
   logic                    csr_write;
   ske_pkg::csr_index_type  csr_index;
   logic signed [EXT_W-1:0] scaled_wide;
   logic [VAR_W:0]          pp_sum;
   logic                    div_done;
   logic [FRAC_BITS-1:0]    gain;
   logic [FRAC_BITS-1:0]    one_minus_gain;
   logic signed [DIFF_W:0]  est_prod;
   logic signed [DIFF_W:0]  var_prod;
   logic                    est_done;
   logic                    var_done;
   logic                    out_free;

   // Register port: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = ske_pkg::csr_index_type'(csr_paddr[ske_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      meas_var_in = meas_var_ff;
      proc_var_in = proc_var_ff;
      if (csr_write) begin
         unique case (csr_index)
            ske_pkg::CSR_MEAS_VAR: meas_var_in = csr_pwdata;
            ske_pkg::CSR_PROC_VAR: proc_var_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ske_pkg::CSR_MEAS_VAR: csr_prdata = meas_var_ff;
         ske_pkg::CSR_PROC_VAR: csr_prdata = proc_var_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // Scale the sample to fixed point and clamp to the estimate range
   always_comb begin
      scaled_wide = EXT_W'(req_ch.sample) <<< FRAC_BITS;
      if (scaled_wide > EST_MAX) begin
         scaled_in = EST_MAX[EST_W-1:0];
      end else if (scaled_wide < EST_MIN) begin
         scaled_in = EST_MIN[EST_W-1:0];
      end else begin
         scaled_in = scaled_wide[EST_W-1:0];
      end
   end

   // Predicted variance, saturating, and the innovation
   always_comb begin
      pp_sum  = {1'b0, var_ff} + {1'b0, proc_var_ff};
      pp_in   = pp_sum[VAR_W] ? {VAR_W{1'b1}} : pp_sum[VAR_W-1:0];
      diff_in = DIFF_W'(scaled_ff) - DIFF_W'(prior_ff);
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   // Gain divider, started as the predicted variance is formed
   ske_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_PREDICT),
      .numer    (pp_in),
      .denom    ({1'b0, pp_in} + {1'b0, meas_var_ff}),
      .quotient (gain),
      .done     (div_done)
   );

   // 1 - K in FRAC_BITS bits; a zero gain is handled at the update
   assign one_minus_gain = (~gain) + 1'b1;

   ske_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul_est (
      .clock        (clock),
      .reset        (reset),
      .start        (div_done),
      .multiplicand (diff_ff),
      .multiplier   (gain),
      .product      (est_prod),
      .done         (est_done)
   );

   ske_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul_var (
      .clock        (clock),
      .reset        (reset),
      .start        (div_done),
      .multiplicand ($signed({1'b0, pp_ff})),
      .multiplier   (one_minus_gain),
      .product      (var_prod),
      .done         (var_done)
   );

   // Sequencer and filter state
   always_comb begin
      state_in     = state_ff;
      byp_in       = byp_ff;
      prior_in     = prior_ff;
      var_in       = var_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_est_in   = out_est_ff;
      out_byp_in   = out_byp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byp_in   = (meas_var_ff == '0);
               state_in = (meas_var_ff == '0) ? ST_WRITE : ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            if (est_done) begin
               prior_in = prior_ff + est_prod[EST_W-1:0];
               var_in   = (gain == '0) ? pp_ff : var_prod[VAR_W-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_est_in   = byp_ff ? scaled_ff : prior_ff;
               out_byp_in   = byp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         meas_var_ff  <= '0;
         proc_var_ff  <= '0;
         prior_ff     <= '0;
         var_ff       <= VAR_W'(1) << FRAC_BITS;
         out_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meas_var_ff  <= meas_var_in;
         proc_var_ff  <= proc_var_in;
         prior_ff     <= prior_in;
         var_ff       <= var_in;
         out_valid_ff <= out_valid_in;
         byp_ff       <= byp_in;
      end
      if (req_take) begin
         scaled_ff <= scaled_in;
      end
      if (state_ff == ST_PREDICT) begin
         pp_ff   <= pp_in;
         diff_ff <= diff_in;
      end
      out_est_ff <= out_est_in;
      out_byp_ff <= out_byp_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.estimate = out_est_ff;
   assign rsp_ch.bypassed = out_byp_ff;

   // The two multipliers run in lockstep
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      est_done == var_done)
      else $error("multipliers out of step");

   // Divider and multipliers finish only in their own states
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      (div_done |-> state_ff == ST_DIVIDE) and (est_done |-> state_ff == ST_MULT))
      else $error("unit finished outside its state");

   // A bypassed sample leaves the filter state alone
   a_bypass_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_take && meas_var_ff == '0) |=> $stable(prior_ff) && $stable(var_ff))
      else $error("bypass changed filter state");

   // The update never raises the variance above its prediction
   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT && est_done) |=> var_ff <= $past(pp_ff))
      else $error("variance grew on update");

   // A waiting result is not overwritten
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && out_valid_ff && !rsp_ch.ready) |=> state_ff == ST_WRITE)
      else $error("result overwritten");

endmodule

`default_nettype wire
